// ----- sv/parallel_pitch_period_estimator_defines.svh -----
// -----------------------------------------------------------------------------
// Assertion macros used by the pitch period estimator back end (ppe_back).
// Both macros assume a clock named clk and an active-low reset named rst_n.
// -----------------------------------------------------------------------------
`ifndef PARALLEL_PITCH_PERIOD_ESTIMATOR_DEFINES_SVH
`define PARALLEL_PITCH_PERIOD_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PPE_ASSERT_IMP(label, ant, con) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("pitch estimator assertion failed");
// Next-cycle implication.
`define PPE_ASSERT_NXT(label, ant, con) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("pitch estimator assertion failed");
`else
`define PPE_ASSERT_IMP(label, ant, con)
`define PPE_ASSERT_NXT(label, ant, con)
`endif
`endif

// ----- sv/ppe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppe_pkg
// Types and constants shared by the pitch period estimator modules.
// -----------------------------------------------------------------------------
package ppe_pkg;

  localparam int DETECTORS   = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IMP_BITS    = 17;
  localparam int LEVEL_BITS  = 18;
  localparam int DET_IDX_W   = 3;
  localparam int SCORE_BITS  = 6;
  localparam int RATE_BITS   = 18;
  localparam int DIVIDEND_W  = RATE_BITS + 8;
  localparam int PITCH_BITS  = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [DET_IDX_W-1:0]  LAST_DET  = DET_IDX_W'(DETECTORS - 1);
  // Detector timers start just past the default blanking time of 216.
  localparam logic [COUNT_BITS-1:0] SINCE_PULSE_RST = COUNT_BITS'(217);

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLANK_TIME   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COINCIDENCE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LONGEST      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORTEST     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_INTERVAL = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PITCH_LIMITS = 3'd7;

  typedef struct packed {
    logic [RATE_BITS-1:0]  sample_rate;
    logic [COUNT_BITS-1:0] blank_time;
    logic [15:0]           decay_factor;
    logic [15:0]           coincidence_threshold;
    logic [COUNT_BITS-1:0] longest_period;
    logic [COUNT_BITS-1:0] shortest_period;
    logic [COUNT_BITS-1:0] output_interval;
    logic [31:0]           pitch_limits;
  } cfg_t;

  // Period estimates of all detectors at the moment a result is due.
  typedef struct packed {
    logic [DETECTORS-1:0][COUNT_BITS-1:0] cur;
    logic [DETECTORS-1:0][COUNT_BITS-1:0] prev;
    logic [DETECTORS-1:0][COUNT_BITS-1:0] old;
  } snap_t;

endpackage
`default_nettype wire

// ----- sv/ppe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppe_front
// Peak and valley finder and the six blanking/decay detectors, one detector
// per cycle. Pushes a snapshot of the estimates when a result is due.
// -----------------------------------------------------------------------------
module ppe_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ppe_pkg::cfg_t                  cfg,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ppe_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic                           q_full,
  output logic                                q_push,
  output ppe_pkg::snap_t                      q_data
);
  import ppe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                   state_r;
  logic [DET_IDX_W-1:0]         idx_r;
  logic                         emit_r;
  logic signed [SAMPLE_BITS-1:0] prev_sample_r, older_sample_r, last_peak_r, last_valley_r;
  logic [COUNT_BITS-1:0]        interval_r;
  logic [IMP_BITS-1:0]          imp_r  [DETECTORS];
  logic [LEVEL_BITS-1:0]        lvl_r  [DETECTORS];
  logic [COUNT_BITS-1:0]        cur_r  [DETECTORS];
  logic [COUNT_BITS-1:0]        prev_r [DETECTORS];
  logic [COUNT_BITS-1:0]        old_r  [DETECTORS];
  logic [COUNT_BITS-1:0]        sp_r   [DETECTORS];

  logic                         accept;
  logic signed [SAMPLE_BITS-1:0] val;
  logic signed [SAMPLE_BITS+1:0] v1x, peakx, valleyx;
  logic                         is_peak, is_valley;
  logic [IMP_BITS-1:0]          imp_new [DETECTORS];
  logic [LEVEL_BITS-1:0]        step_lvl;
  logic [COUNT_BITS-1:0]        step_sp;
  logic [LEVEL_BITS+15:0]       product;
  logic                         fire;
  logic [LEVEL_BITS-1:0]        lvl_nxt;
  logic [COUNT_BITS-1:0]        sp_nxt;

  assign in_tready = (state_r == ST_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign val       = signed'(in_sample);
  assign v1x       = (SAMPLE_BITS+2)'(prev_sample_r);
  assign peakx     = (SAMPLE_BITS+2)'(last_peak_r);
  assign valleyx   = (SAMPLE_BITS+2)'(last_valley_r);
  assign is_peak   = (val > 0) && (val <= prev_sample_r) && (prev_sample_r >= older_sample_r);
  assign is_valley = (val < 0) && (val >= prev_sample_r) && (prev_sample_r <= older_sample_r);

  // Last peak is never negative and last valley never positive, so all
  // impulses are non-negative and fit in IMP_BITS.
  always_comb begin
    for (int d = 0; d < DETECTORS; d++) begin
      imp_new[d] = '0;
    end
    if (is_peak) begin
      imp_new[0] = IMP_BITS'(v1x);
      imp_new[1] = IMP_BITS'(v1x - valleyx);
      imp_new[2] = (prev_sample_r > last_peak_r) ? IMP_BITS'(v1x - peakx) : '0;
    end
    if (is_valley) begin
      imp_new[3] = IMP_BITS'(-v1x);
      imp_new[4] = IMP_BITS'(peakx - v1x);
      imp_new[5] = (prev_sample_r < last_valley_r) ? IMP_BITS'(valleyx - v1x) : '0;
    end
  end

  always_comb begin
    step_lvl = lvl_r[idx_r];
    step_sp  = sp_r[idx_r];
    product  = step_lvl * cfg.decay_factor;
    fire     = 1'b0;
    lvl_nxt  = step_lvl;
    sp_nxt   = step_sp;
    if (step_sp > cfg.blank_time) begin
      if (LEVEL_BITS'(imp_r[idx_r]) > step_lvl) begin
        fire    = 1'b1;
        lvl_nxt = LEVEL_BITS'(imp_r[idx_r]);
        sp_nxt  = '0;
      end else begin
        lvl_nxt = product[LEVEL_BITS+15:16];
      end
    end
    if (sp_nxt != COUNT_MAX) begin
      sp_nxt = sp_nxt + 1'b1;
    end
  end

  always_comb begin
    q_push = (state_r == ST_PUSH);
    for (int d = 0; d < DETECTORS; d++) begin
      q_data.cur[d]  = cur_r[d];
      q_data.prev[d] = prev_r[d];
      q_data.old[d]  = old_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      emit_r         <= 1'b0;
      prev_sample_r  <= '0;
      older_sample_r <= '0;
      last_peak_r    <= '0;
      last_valley_r  <= '0;
      interval_r     <= '0;
      for (int d = 0; d < DETECTORS; d++) begin
        lvl_r[d]  <= '0;
        cur_r[d]  <= '0;
        prev_r[d] <= '0;
        old_r[d]  <= '0;
        sp_r[d]   <= SINCE_PULSE_RST;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            for (int d = 0; d < DETECTORS; d++) begin
              imp_r[d] <= imp_new[d];
            end
            if (is_peak) begin
              last_peak_r <= prev_sample_r;
            end
            if (is_valley) begin
              last_valley_r <= prev_sample_r;
            end
            older_sample_r <= prev_sample_r;
            prev_sample_r  <= val;
            if (interval_r <= cfg.output_interval) begin
              emit_r <= 1'b0;
              if (interval_r != COUNT_MAX) begin
                interval_r <= interval_r + 1'b1;
              end
            end else begin
              emit_r     <= 1'b1;
              interval_r <= '0;
            end
            idx_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          lvl_r[idx_r] <= lvl_nxt;
          sp_r[idx_r]  <= sp_nxt;
          if (fire) begin
            old_r[idx_r]  <= prev_r[idx_r];
            prev_r[idx_r] <= cur_r[idx_r];
            cur_r[idx_r]  <= step_sp;
          end
          if (idx_r == LAST_DET) begin
            state_r <= emit_r ? ST_PUSH : ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_PUSH: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/ppe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppe_queue
// Two-entry queue of estimate snapshots between the front and back ends.
// -----------------------------------------------------------------------------
module ppe_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ppe_pkg::snap_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output ppe_pkg::snap_t      pop_data
);
  import ppe_pkg::*;

  snap_t      mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ----- sv/ppe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "parallel_pitch_period_estimator_defines.svh"
// -----------------------------------------------------------------------------
// ppe_back
// Coincidence scoring over all detector pairs (one pair a cycle), period
// selection, and a bit-serial divider that turns the period into pitch.
// -----------------------------------------------------------------------------
module ppe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ppe_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire ppe_pkg::snap_t q_data,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [ppe_pkg::PITCH_BITS-1:0] out_pitch,
  output logic [ppe_pkg::COUNT_BITS-1:0] out_period,
  output logic                out_in_range
);
  import ppe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCORE  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam int         DIV_CW    = $clog2(DIVIDEND_W);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIVIDEND_W - 1);

  logic [2:0]             state_r;
  logic [DET_IDX_W-1:0]   i_r, j_r;
  logic [COUNT_BITS-1:0]  erow_r [DETECTORS];
  logic [COUNT_BITS-1:0]  scur_r [DETECTORS];
  logic [COUNT_BITS-1:0]  sprev_r [DETECTORS];
  logic [COUNT_BITS-1:0]  sold_r [DETECTORS];
  logic [SCORE_BITS-1:0]  cnt_r, best_cnt_r;
  logic [COUNT_BITS-1:0]  best_p_r;
  logic [DIV_CW-1:0]      div_cnt_r;
  logic [DIVIDEND_W-1:0]  dividend_r, quot_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [PITCH_BITS-1:0]  pitch_r;
  logic                   inr_r;
  logic                   out_tvalid_r;
  logic [PITCH_BITS-1:0]  out_pitch_r;
  logic [COUNT_BITS-1:0]  out_period_r;
  logic                   out_inr_r;

  logic signed [COUNT_BITS+2:0] e, a, b, c;
  logic [2:0]             hits;
  logic [SCORE_BITS-1:0]  cnt_nxt;
  logic                   e_in_range, p_in_range;
  logic [COUNT_BITS:0]    rem_shift;
  logic                   rem_ge;

  function automatic logic hit(input logic signed [COUNT_BITS+2:0] d,
                               input logic [15:0] th);
    logic [COUNT_BITS+2:0] mag;
    mag = d[COUNT_BITS+2] ? unsigned'(-d) : unsigned'(d);
    return mag <= (COUNT_BITS+3)'(th);
  endfunction

  assign e = signed'((COUNT_BITS+3)'(erow_r[0]));
  assign a = signed'((COUNT_BITS+3)'(scur_r[0]));
  assign b = signed'((COUNT_BITS+3)'(sprev_r[0]));
  assign c = signed'((COUNT_BITS+3)'(sold_r[0]));

  always_comb begin
    hits = 3'(hit(e - a, cfg.coincidence_threshold))
         + 3'(hit(e - b, cfg.coincidence_threshold))
         + 3'(hit(e - c, cfg.coincidence_threshold))
         + 3'(hit(e - a - b, cfg.coincidence_threshold))
         + 3'(hit(e - b - c, cfg.coincidence_threshold))
         + 3'(hit(e - a - b - c, cfg.coincidence_threshold));
  end

  assign cnt_nxt    = cnt_r + SCORE_BITS'(hits);
  assign e_in_range = (erow_r[0] <= cfg.longest_period) && (erow_r[0] >= cfg.shortest_period);
  assign p_in_range = (best_p_r <= cfg.longest_period) && (best_p_r >= cfg.shortest_period);
  assign rem_shift  = {rem_r, dividend_r[DIVIDEND_W-1]};
  assign rem_ge     = rem_shift >= (COUNT_BITS+1)'(best_p_r);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;

  assign out_tvalid   = out_tvalid_r;
  assign out_pitch    = out_pitch_r;
  assign out_period   = out_period_r;
  assign out_in_range = out_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      div_cnt_r    <= '0;
    end else begin
      // In ST_DONE the output register is reloaded below instead.
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            for (int d = 0; d < DETECTORS; d++) begin
              erow_r[d]  <= q_data.cur[d];
              scur_r[d]  <= q_data.cur[d];
              sprev_r[d] <= q_data.prev[d];
              sold_r[d]  <= q_data.old[d];
            end
            i_r     <= '0;
            j_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_SCORE;
          end
        end
        ST_SCORE: begin
          // The snapshot rotates each cycle; the row under test each row.
          for (int d = 0; d < DETECTORS; d++) begin
            scur_r[d]  <= scur_r[(d + 1) % DETECTORS];
            sprev_r[d] <= sprev_r[(d + 1) % DETECTORS];
            sold_r[d]  <= sold_r[(d + 1) % DETECTORS];
          end
          if (j_r == LAST_DET) begin
            if ((i_r == '0) || (e_in_range && (cnt_nxt > best_cnt_r))) begin
              best_cnt_r <= cnt_nxt;
              best_p_r   <= erow_r[0];
            end
            for (int d = 0; d < DETECTORS; d++) begin
              erow_r[d] <= erow_r[(d + 1) % DETECTORS];
            end
            cnt_r <= '0;
            j_r   <= '0;
            if (i_r == LAST_DET) begin
              state_r <= ST_DECIDE;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            cnt_r <= cnt_nxt;
            j_r   <= j_r + 1'b1;
          end
        end
        ST_DECIDE: begin
          inr_r <= p_in_range;
          if (best_p_r > cfg.longest_period) begin
            pitch_r <= {cfg.pitch_limits[15:0], 8'd0};
            state_r <= ST_DONE;
          end else if (best_p_r < cfg.shortest_period) begin
            pitch_r <= {cfg.pitch_limits[31:16], 8'd0};
            state_r <= ST_DONE;
          end else if (best_p_r == '0) begin
            pitch_r <= '1;
            state_r <= ST_DONE;
          end else begin
            dividend_r <= {cfg.sample_rate, 8'd0};
            rem_r      <= '0;
            quot_r     <= '0;
            div_cnt_r  <= '0;
            state_r    <= ST_DIV;
          end
        end
        ST_DIV: begin
          dividend_r <= {dividend_r[DIVIDEND_W-2:0], 1'b0};
          rem_r      <= rem_ge ? COUNT_BITS'(rem_shift - (COUNT_BITS+1)'(best_p_r))
                               : COUNT_BITS'(rem_shift);
          quot_r     <= {quot_r[DIVIDEND_W-2:0], rem_ge};
          if (div_cnt_r == DIV_LAST) begin
            state_r <= ST_DONE;
          end else begin
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_period_r <= best_p_r;
            out_inr_r    <= inr_r;
            if (p_in_range && (best_p_r != '0)) begin
              out_pitch_r <= (quot_r[DIVIDEND_W-1:PITCH_BITS] != '0) ? '1
                                                                     : quot_r[PITCH_BITS-1:0];
            end else begin
              out_pitch_r <= pitch_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `PPE_ASSERT_IMP(a_div_rem_below_divisor, state_r == ST_DIV, rem_r < best_p_r)
  `PPE_ASSERT_NXT(a_pop_starts_score, q_pop, state_r == ST_SCORE && i_r == '0 && j_r == '0)
  `PPE_ASSERT_IMP(a_done_from_range, state_r == ST_SCORE, i_r != 3'd6 && i_r != 3'd7 && j_r != 3'd6 && j_r != 3'd7)

endmodule
`default_nettype wire

// ----- sv/parallel_pitch_period_estimator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// parallel_pitch_period_estimator
// Six-detector pitch period estimator with a Q8 Hz pitch output.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one signed 16-bit audio sample per request.
//   Output channel out_*: one pitch result each time the interval counter
//   passes output_interval; most samples produce no result.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle, no read-back;
//   the user must write only while the block is idle; the block does not enforce it.
// Flow:
//   A sample occupies the front end for the peak finder step plus one step
//   per detector, and a push step when it triggers a result; the front end
//   takes no new sample until it is through. A result passes through the
//   scoring of every detector pair and period selection, then the bit-serial
//   divider when the period is in range, and is then loaded into the output
//   register once that register is free.
//   A two-entry snapshot queue lets the front keep taking samples while the
//   back end scores or waits on a stalled receiver; when it fills,
//   in_tready drops. A held result stays in the output register.
// Reset: synchronous, active low; configuration registers return to their defaults,
//   detector levels and estimates clear and detector timers restart at SINCE_PULSE_RST.
// -----------------------------------------------------------------------------
module parallel_pitch_period_estimator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [15:0]                     in_tdata,   // [15:0] sample
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [47:0]                          out_tdata,  // [23:0] pitch_q8,
                                                           // [39:24] chosen_period,
                                                           // [40] period_in_range
  input  wire logic                            cfg_we,
  input  wire logic [ppe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ppe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ppe_pkg::*;

  cfg_t                   cfg_r;
  logic                   q_full, q_push, q_pop, q_valid;
  snap_t                  q_wdata, q_rdata;
  logic [PITCH_BITS-1:0]  pitch;
  logic [COUNT_BITS-1:0]  period;
  logic                   in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate           <= RATE_BITS'(48000);
      cfg_r.blank_time            <= 16'd216;
      cfg_r.decay_factor          <= 16'd65357;
      cfg_r.coincidence_threshold <= 16'd13;
      cfg_r.longest_period        <= 16'd960;
      cfg_r.shortest_period       <= 16'd240;
      cfg_r.output_interval       <= 16'd187;
      cfg_r.pitch_limits          <= 32'd13107250;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_RATE:  cfg_r.sample_rate           <= cfg_wdata[RATE_BITS-1:0];
        REG_BLANK_TIME:   cfg_r.blank_time            <= cfg_wdata[15:0];
        REG_DECAY:        cfg_r.decay_factor          <= cfg_wdata[15:0];
        REG_COINCIDENCE:  cfg_r.coincidence_threshold <= cfg_wdata[15:0];
        REG_LONGEST:      cfg_r.longest_period        <= cfg_wdata[15:0];
        REG_SHORTEST:     cfg_r.shortest_period       <= cfg_wdata[15:0];
        REG_OUT_INTERVAL: cfg_r.output_interval       <= cfg_wdata[15:0];
        REG_PITCH_LIMITS: cfg_r.pitch_limits          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ppe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  ppe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  ppe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_pitch    (pitch),
    .out_period   (period),
    .out_in_range (in_range)
  );

  assign out_tdata = {7'd0, in_range, period, pitch};

endmodule
`default_nettype wire
